/* rtl/rmd_pkg.sv */
// shared types, constants and round tables for the ripemd-160 hash pipeline
package rmd_pkg;

    localparam int NumRounds = 80;
    localparam int NumWords  = 16;
    localparam int MsgWords  = 8;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_widx;
    typedef logic [4:0]  t_rot;

    // working state of both lines
    typedef struct packed {
        t_word al, bl, cl, dl, el;
        t_word ar, br, cr, dr, er;
    } t_state;

    // payload moving down the chain of round cells
    typedef struct packed {
        t_state                       st;
        logic [MsgWords-1:0][31:0]    msg;
    } t_stage;

    localparam t_word InitH0 = 32'h67452301;
    localparam t_word InitH1 = 32'hEFCDAB89;
    localparam t_word InitH2 = 32'h98BADCFE;
    localparam t_word InitH3 = 32'h10325476;
    localparam t_word InitH4 = 32'hC3D2E1F0;

    localparam t_word PadWord8  = 32'h00000080;
    localparam t_word PadWord14 = 32'h00000100;

    function automatic t_widx word_left(input int i);
        logic [79:0][3:0] tbl;
        tbl = {4'd13, 4'd15, 4'd6, 4'd11, 4'd8, 4'd3, 4'd1, 4'd14,
               4'd10, 4'd2, 4'd12, 4'd7, 4'd9, 4'd5, 4'd0, 4'd4,
               4'd2, 4'd6, 4'd5, 4'd14, 4'd15, 4'd7, 4'd3, 4'd13,
               4'd4, 4'd12, 4'd8, 4'd0, 4'd10, 4'd11, 4'd9, 4'd1,
               4'd12, 4'd5, 4'd11, 4'd13, 4'd6, 4'd0, 4'd7, 4'd2,
               4'd1, 4'd8, 4'd15, 4'd9, 4'd4, 4'd14, 4'd10, 4'd3,
               4'd8, 4'd11, 4'd14, 4'd2, 4'd5, 4'd9, 4'd0, 4'd12,
               4'd3, 4'd15, 4'd6, 4'd10, 4'd1, 4'd13, 4'd4, 4'd7,
               4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
               4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
        return tbl[i];
    endfunction

    function automatic t_widx word_right(input int i);
        logic [79:0][3:0] tbl;
        tbl = {4'd11, 4'd9, 4'd3, 4'd0, 4'd14, 4'd13, 4'd2, 4'd6,
               4'd7, 4'd8, 4'd5, 4'd1, 4'd4, 4'd10, 4'd15, 4'd12,
               4'd14, 4'd10, 4'd7, 4'd9, 4'd13, 4'd2, 4'd12, 4'd5,
               4'd0, 4'd15, 4'd11, 4'd3, 4'd1, 4'd4, 4'd6, 4'd8,
               4'd13, 4'd4, 4'd0, 4'd10, 4'd2, 4'd12, 4'd8, 4'd11,
               4'd9, 4'd6, 4'd14, 4'd7, 4'd3, 4'd1, 4'd5, 4'd15,
               4'd2, 4'd1, 4'd9, 4'd4, 4'd12, 4'd8, 4'd15, 4'd14,
               4'd10, 4'd5, 4'd13, 4'd0, 4'd7, 4'd3, 4'd11, 4'd6,
               4'd12, 4'd3, 4'd10, 4'd1, 4'd8, 4'd15, 4'd6, 4'd13,
               4'd4, 4'd11, 4'd2, 4'd9, 4'd0, 4'd7, 4'd14, 4'd5};
        return tbl[i];
    endfunction

    function automatic t_rot rot_left(input int i);
        logic [79:0][4:0] tbl;
        tbl = {5'd6, 5'd5, 5'd8, 5'd11, 5'd14, 5'd13, 5'd12, 5'd5,
               5'd12, 5'd13, 5'd8, 5'd6, 5'd11, 5'd5, 5'd15, 5'd9,
               5'd12, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd14, 5'd9,
               5'd8, 5'd9, 5'd15, 5'd14, 5'd15, 5'd14, 5'd12, 5'd11,
               5'd5, 5'd7, 5'd12, 5'd5, 5'd6, 5'd13, 5'd8, 5'd14,
               5'd15, 5'd13, 5'd9, 5'd14, 5'd7, 5'd6, 5'd13, 5'd11,
               5'd12, 5'd13, 5'd7, 5'd11, 5'd9, 5'd15, 5'd12, 5'd7,
               5'd15, 5'd7, 5'd9, 5'd11, 5'd13, 5'd8, 5'd6, 5'd7,
               5'd8, 5'd9, 5'd7, 5'd6, 5'd15, 5'd14, 5'd13, 5'd11,
               5'd9, 5'd7, 5'd8, 5'd5, 5'd12, 5'd15, 5'd14, 5'd11};
        return tbl[i];
    endfunction

    function automatic t_rot rot_right(input int i);
        logic [79:0][4:0] tbl;
        tbl = {5'd11, 5'd11, 5'd13, 5'd15, 5'd5, 5'd6, 5'd13, 5'd8,
               5'd6, 5'd14, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd8,
               5'd8, 5'd15, 5'd5, 5'd12, 5'd9, 5'd12, 5'd9, 5'd6,
               5'd14, 5'd6, 5'd14, 5'd14, 5'd11, 5'd8, 5'd5, 5'd15,
               5'd5, 5'd7, 5'd13, 5'd13, 5'd14, 5'd5, 5'd13, 5'd12,
               5'd14, 5'd6, 5'd6, 5'd8, 5'd11, 5'd15, 5'd7, 5'd9,
               5'd11, 5'd13, 5'd15, 5'd6, 5'd7, 5'd12, 5'd7, 5'd7,
               5'd11, 5'd9, 5'd8, 5'd12, 5'd7, 5'd15, 5'd13, 5'd9,
               5'd6, 5'd12, 5'd14, 5'd14, 5'd11, 5'd8, 5'd7, 5'd7,
               5'd5, 5'd15, 5'd15, 5'd13, 5'd11, 5'd9, 5'd9, 5'd8};
        return tbl[i];
    endfunction

    function automatic t_word add_left(input int grp);
        case (grp)
            0: return 32'h00000000;
            1: return 32'h5A827999;
            2: return 32'h6ED9EBA1;
            3: return 32'h8F1BBCDC;
            default: return 32'hA953FD4E;
        endcase
    endfunction

    function automatic t_word add_right(input int grp);
        case (grp)
            0: return 32'h50A28BE6;
            1: return 32'h5C4DD124;
            2: return 32'h6D703EF3;
            3: return 32'h7A6D76E9;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic t_word bool_fn(input int sel, input t_word x, input t_word y,
                                      input t_word z);
        case (sel)
            0: return x ^ y ^ z;
            1: return (x & y) | (~x & z);
            2: return (x | ~y) ^ z;
            3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    function automatic t_word rotl(input t_word x, input t_rot n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage

/* rtl/rmd_stream_if.sv */
// valid/ready channel carrying a fixed payload type
interface rmd_stream_if #(parameter int Width = 256);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/rmd_round_cell.sv */
// one round cell: a round of both lines plus its pipeline register
module rmd_round_cell
    import rmd_pkg::*;
#(
    parameter int Round = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);
    localparam int Grp = Round / 16;

    logic [NumWords-1:0][31:0] w;
    t_word  tl, tr;
    t_state s;
    t_stage n_stage;
    t_stage r_stage;
    logic   r_valid;

    // padded message block
    always_comb begin
        w = '0;
        for (int k = 0; k < MsgWords; k++) w[k] = i_stage.msg[k];
        w[8]  = PadWord8;
        w[14] = PadWord14;
    end

    // round function on both lines
    always_comb begin
        s  = i_stage.st;
        tl = rotl(s.al + bool_fn(Grp, s.bl, s.cl, s.dl) + w[word_left(Round)]
                  + add_left(Grp), rot_left(Round)) + s.el;
        tr = rotl(s.ar + bool_fn(4 - Grp, s.br, s.cr, s.dr) + w[word_right(Round)]
                  + add_right(Grp), rot_right(Round)) + s.er;
        n_stage     = i_stage;
        n_stage.st.al = s.el;
        n_stage.st.el = s.dl;
        n_stage.st.dl = rotl(s.cl, 5'd10);
        n_stage.st.cl = s.bl;
        n_stage.st.bl = tl;
        n_stage.st.ar = s.er;
        n_stage.st.er = s.dr;
        n_stage.st.dr = rotl(s.cr, 5'd10);
        n_stage.st.cr = s.br;
        n_stage.st.br = tr;
    end

    // stage register, advances with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

/* rtl/ripemd160_32byte_message_hash.sv */
// top level: 80-cell ripemd-160 pipeline for 32-byte messages
// One message enters per cycle while the chain is not stalled: the 80 round
// cells each hold one round of both lines in a register, and a final register adds the
// combination. The whole chain advances together and stalls only when the output
// register holds a digest that is not taken, so throughput is one transfer per cycle.
module ripemd160_32byte_message_hash
    import rmd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmd_stream_if.sink   i_msg,
    rmd_stream_if.source o_digest
);
    logic   [NumRounds:0] v;
    t_stage               stg [NumRounds+1];
    logic                 en;
    logic                 r_out_valid;
    logic   [159:0]       r_out_data;
    logic   [159:0]       n_out_data;
    t_state               f;

    // chain advances unless the output holds an untaken digest
    assign en          = !r_out_valid || o_digest.ready;
    assign i_msg.ready = en;

    // initial state and message into the first cell
    assign stg[0].st  = '{InitH0, InitH1, InitH2, InitH3, InitH4,
                          InitH0, InitH1, InitH2, InitH3, InitH4};
    assign stg[0].msg = i_msg.data[255:0];
    assign v[0]       = i_msg.valid;

    for (genvar g = 0; g < NumRounds; g++) begin : g_cell
        rmd_round_cell #(.Round(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_stage (stg[g]),
            .o_valid (v[g+1]),
            .o_stage (stg[g+1])
        );
    end

    // final combination
    always_comb begin
        f = stg[NumRounds].st;
        n_out_data[31:0]    = InitH1 + f.cl + f.dr;
        n_out_data[63:32]   = InitH2 + f.dl + f.er;
        n_out_data[95:64]   = InitH3 + f.el + f.ar;
        n_out_data[127:96]  = InitH4 + f.al + f.br;
        n_out_data[159:128] = InitH0 + f.bl + f.cr;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v[NumRounds];
        end
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_digest.valid = r_out_valid;
    assign o_digest.data  = r_out_data;

`ifndef ASSERT_OFF
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_digest.ready |=> r_out_valid && $stable(r_out_data))
        else $error("digest changed while stalled");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_msg.ready)
        else $error("input blocked with empty output");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && v[NumRounds] |=> r_out_valid)
        else $error("digest lost at output");
`endif
endmodule
